>>> rtl/core/fac_pkg.sv
// Package for the fully associative cache: word types for both channels,
// the controller state type and the command bundle to the datapath.
// Depends on nothing; every other file of the block imports it.
package fac_pkg;

    // Address width is fixed by the request word layout.
    localparam int ADDR_BITS = 16;
    localparam int DATA_BITS = 32;
    localparam int COUNT_BITS = 32;

    // Operation codes carried in the func field.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Request word.
    typedef struct packed {
        logic                        func;
        logic [ADDR_BITS-1:0]        address;
        logic signed [DATA_BITS-1:0] write_data;
    } fac_req_t;

    // Response word.
    typedef struct packed {
        logic                        hit;
        logic signed [DATA_BITS-1:0] read_data;
        logic                        insert_dropped;
        logic [COUNT_BITS-1:0]       hit_total;
        logic [COUNT_BITS-1:0]       miss_total;
    } fac_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } fac_state_t;

    // Commands from the controller to the datapath and output stage.
    typedef struct packed {
        logic capture;
        logic execute;
        logic deliver;
    } fac_cmd_t;

endpackage

>>> rtl/core/fac_datapath.sv
// Datapath of the fully associative cache: tags, valid bits, word memory,
// hit and miss counters and the parallel tag compare.
// Depends on fac_pkg; driven by commands from fac_ctrl.
module fac_datapath
    import fac_pkg::*;
#(
    parameter int NUM_LINES      = 16,
    parameter int WORDS_PER_LINE = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  fac_cmd_t cmd,
    input  fac_req_t req_word,
    output fac_rsp_t result
);

    localparam int LINE_W      = $clog2(NUM_LINES);
    localparam int OFF_W       = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int MEM_DEPTH   = NUM_LINES * WORDS_PER_LINE;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    // Reciprocal for the word offset: exact for every address below 2^ADDR_BITS.
    localparam int RECIP_SHIFT = ADDR_BITS + 6;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + WORDS_PER_LINE - 1) / WORDS_PER_LINE;
    localparam int PROD_W      = ADDR_BITS + RECIP_W;

    // Captured request and its line quotient.
    fac_req_t                 item_reg;
    logic [ADDR_BITS-1:0]     quot_reg;
    logic [PROD_W-1:0]        prod;

    // Line state.
    logic [NUM_LINES-1:0]     valid_reg;
    logic [ADDR_BITS-1:0]     tag_reg [NUM_LINES];
    logic [DATA_BITS-1:0]     mem [MEM_DEPTH];
    logic [DATA_BITS-1:0]     rdata_reg;
    logic [COUNT_BITS-1:0]    hit_cnt_reg;
    logic [COUNT_BITS-1:0]    hit_cnt_next;
    logic [COUNT_BITS-1:0]    miss_cnt_reg;
    logic [COUNT_BITS-1:0]    miss_cnt_next;
    logic                     hit_reg;
    logic                     drop_reg;

    // Compare and selection.
    logic [NUM_LINES-1:0]     match;
    logic                     any_match;
    logic                     any_free;
    logic [LINE_W-1:0]        hit_idx;
    logic [LINE_W-1:0]        free_idx;
    logic [LINE_W-1:0]        sel_idx;
    logic [ADDR_BITS-1:0]     rem;
    logic [OFF_W-1:0]         offset;
    logic [MEM_AW-1:0]        mem_addr;
    logic                     is_insert;
    logic                     mem_write;
    logic                     mem_read;

    // Quotient by the line size, taken as the request is captured.
    assign prod = PROD_W'(req_word.address) * PROD_W'(RECIP_W'(RECIP));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_word;
            quot_reg <= prod[RECIP_SHIFT +: ADDR_BITS];
        end
    end

    // Word offset within the line.
    assign rem    = item_reg.address - ADDR_BITS'(quot_reg * WORDS_PER_LINE);
    assign offset = rem[OFF_W-1:0];

    // Tag compare against every valid line.
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == item_reg.address);
        end
    end

    assign any_match = |match;
    assign any_free  = ~&valid_reg;

    // Lowest matching line and lowest invalid line.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = LINE_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = LINE_W'(i);
            end
        end
    end

    // Word memory address and access enables.
    assign is_insert = (item_reg.func == FUNC_INSERT);
    assign sel_idx   = is_insert ? free_idx : hit_idx;
    assign mem_addr  = MEM_AW'(sel_idx * WORDS_PER_LINE) + MEM_AW'(offset);
    assign mem_write = cmd.execute && is_insert && any_free;
    assign mem_read  = cmd.execute && !is_insert;

    // Word memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            mem[mem_addr] <= item_reg.write_data;
        end
        if (mem_read)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Tag store, written into the chosen free line.
    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            tag_reg[free_idx] <= item_reg.address;
        end
    end

    // Outcome flags of the current request.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            hit_reg  <= !is_insert && any_match;
            drop_reg <= is_insert && !any_free;
        end
    end

    // Counter updates on lookups.
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (mem_read)
        begin
            if (any_match)
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
            else
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    // Valid bits and counters, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            if (mem_write)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // Response word for the output stage.
    always_comb
    begin
        result.hit            = hit_reg;
        result.read_data      = hit_reg ? rdata_reg : '0;
        result.insert_dropped = drop_reg;
        result.hit_total      = hit_cnt_reg;
        result.miss_total     = miss_cnt_reg;
    end

endmodule

>>> rtl/core/fac_ctrl.sv
// Controller of the fully associative cache: sequences capture, tag compare
// with memory access, and delivery of the response word.
// Depends on fac_pkg; drives fac_datapath and the output register.
module fac_ctrl
    import fac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     out_free,
    output logic     req_ready,
    output fac_cmd_t cmd
);

    fac_state_t state_reg;
    fac_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = req_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: a new word is taken while the previous response is handed on.
    always_comb
    begin
        req_ready   = 1'b0;
        cmd.execute = 1'b0;
        cmd.deliver = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_LOOK:
            begin
                cmd.execute = 1'b1;
            end
            ST_DONE:
            begin
                req_ready   = out_free;
                cmd.deliver = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        cmd.capture = req_valid && req_ready;
    end

`ifndef SYNTHESIS
    // An accepted word is always processed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("accepted word not processed next cycle");

    // Every lookup or insert leads to a response waiting to be delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> (state_reg == ST_DONE))
        else $error("processed word not held for delivery");

    // A response is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |-> out_free)
        else $error("response delivered into a full output register");

    // Processing and delivery never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.execute && (cmd.deliver || cmd.capture)))
        else $error("capture or delivery during processing");
`endif

endmodule

>>> rtl/core/fully_associative_cache.sv
// Top level of the fully associative cache: request and response channels,
// the response output register, controller and datapath.
// Depends on fac_pkg, fac_ctrl and fac_datapath.
//
// Usage: a request word (func, address, write_data) is offered on req_valid
// with req_word and taken when req_ready is high. func selects a lookup or an
// insert; each request produces exactly one response word on rsp_valid,
// rsp_word, taken when rsp_ready is high.
// Sequence: the accepted request is registered, the tag compare and word
// memory access run in ST_LOOK, and the response formed in ST_DONE is
// loaded into the output register once that register is free.
// Requests are handled one at a time, as set by the single-port word memory,
// which is read after the parallel tag compare, and because each request
// must see the table left by the one before.
// Stalls: the output register holds the response while rsp_ready is low; one
// further request can be processed, then req_ready falls until it drains.
// Reset: rst_n clears all valid bits, both counters and the control state at
// once; tags and memory words are not cleared, so the block is ready at the
// release of reset.
module fully_associative_cache
    import fac_pkg::*;
#(
    parameter int NUM_LINES      = 16,
    parameter int WORDS_PER_LINE = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fac_req_t req_word,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output fac_rsp_t rsp_word
);

    fac_cmd_t cmd;
    fac_rsp_t result;
    fac_rsp_t out_word_reg;
    logic     out_valid_reg;
    logic     out_free;

    // The output register may be loaded when empty or being drained.
    assign out_free = !out_valid_reg || rsp_ready;

    fac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .out_free  (out_free),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    fac_datapath #(
        .NUM_LINES      (NUM_LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .result   (result)
    );

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Response word register.
    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            out_word_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the fully associative cache: a table of directed
// words followed by random lookups and inserts, checked against a local predictor.
// Depends on fac_pkg and the fully_associative_cache top level.
module testbench
    import fac_pkg::*;
();

    localparam int LINES       = 16;
    localparam int WORDS       = 4;
    localparam int RANDOM_REQS = 1435;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;

    // One row of the directed table; a typed row carries its own answer.
    typedef struct {
        fac_req_t req;
        bit       typed;
        fac_rsp_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    fac_req_t req_word;
    logic     rsp_valid;
    logic     rsp_ready;
    fac_rsp_t rsp_word;

    // Predictor copy of the cache contents and counters.
    bit                  mdl_valid [LINES];
    logic [ADDR_BITS-1:0] mdl_tag [LINES];
    logic [DATA_BITS-1:0] mdl_word [LINES*WORDS];
    logic [COUNT_BITS-1:0] mdl_hits;
    logic [COUNT_BITS-1:0] mdl_misses;

    fac_rsp_t             pending_rsp [$];
    logic [ADDR_BITS-1:0] inserted_addr [$];
    dir_row_t             directed [$];

    int  error_count;
    int  cycle_count;
    int  lookups_seen;
    int  hits_seen;
    int  drops_seen;
    int  inserts_seen;
    bit  steady;

    fully_associative_cache dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Works out the response word for one accepted request and updates the copy.
    function automatic fac_rsp_t cache_model_step(fac_req_t req);
        fac_rsp_t rsp;
        int       offset;
        bit       found;
        offset = int'(req.address) % WORDS;
        found  = 1'b0;
        rsp    = '0;
        if (req.func == FUNC_LOOKUP)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                if (!found && mdl_valid[i] && mdl_tag[i] == req.address)
                begin
                    found         = 1'b1;
                    rsp.hit       = 1'b1;
                    rsp.read_data = mdl_word[i*WORDS + offset];
                end
            end
            if (found)
                mdl_hits = mdl_hits + 1;
            else
                mdl_misses = mdl_misses + 1;
        end
        else
        begin
            rsp.insert_dropped = 1'b1;
            for (int i = 0; i < LINES; i++)
            begin
                if (!found && !mdl_valid[i])
                begin
                    found                    = 1'b1;
                    mdl_valid[i]             = 1'b1;
                    mdl_tag[i]               = req.address;
                    mdl_word[i*WORDS+offset] = req.write_data;
                    rsp.insert_dropped       = 1'b0;
                end
            end
        end
        rsp.hit_total  = mdl_hits;
        rsp.miss_total = mdl_misses;
        return rsp;
    endfunction

    // Flags are given as plain numbers in the table; any non-zero value sets them.
    function automatic dir_row_t make_row(logic func, logic [15:0] addr, logic [31:0] data,
                                          int typed, int hit, logic [31:0] rdata,
                                          int drop, logic [31:0] hits, logic [31:0] misses);
        dir_row_t row;
        row.req.func            = func;
        row.req.address         = addr;
        row.req.write_data      = data;
        row.typed               = (typed != 0);
        row.want.hit            = (hit != 0);
        row.want.read_data      = rdata;
        row.want.insert_dropped = (drop != 0);
        row.want.hit_total      = hits;
        row.want.miss_total     = misses;
        return row;
    endfunction

    // Random request: mostly lookups of addresses already offered for insert.
    function automatic fac_req_t make_random_req();
        fac_req_t req;
        int       roll;
        roll           = $urandom_range(99);
        req.write_data = $urandom;
        if (roll < 10)
        begin
            req.func = FUNC_INSERT;
            if (inserted_addr.size() > 0 && $urandom_range(3) == 0)
                req.address = inserted_addr[$urandom_range(inserted_addr.size()-1)];
            else
                req.address = ADDR_BITS'($urandom_range(16'hFFFF));
        end
        else
        begin
            req.func = FUNC_LOOKUP;
            roll     = $urandom_range(99);
            if (roll < 65)
                req.address = inserted_addr[$urandom_range(inserted_addr.size()-1)];
            else if (roll < 80)
                req.address = inserted_addr[$urandom_range(inserted_addr.size()-1)]
                              ^ (16'h1 << $urandom_range(ADDR_BITS-1));
            else
                req.address = ADDR_BITS'($urandom_range(16'hFFFF));
        end
        return req;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h, wanted %h", cycle_count, field, got, want);
        error_count++;
    endtask

    // Offers one word from a falling edge and returns at the falling edge after
    // it is taken; outside the steady stretch, idle cycles go in front at random.
    task automatic send_word(fac_req_t req, bit typed, fac_rsp_t want);
        fac_rsp_t predicted;
        while (!steady && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= req;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = cache_model_step(req);
        pending_rsp.push_back(typed ? want : predicted);
        if (req.func == FUNC_INSERT)
            inserted_addr.push_back(req.address);
        @(negedge clk);
    endtask

    // Holds the request channel idle until every response word has arrived.
    task automatic hold_until_drained();
        while (pending_rsp.size() > 0)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // The response side stalls at random outside the steady stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // Response checker: every word taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        fac_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected response", rsp_word.hit_total, '0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_word.hit !== want.hit)
                    report_mismatch("hit", 32'(rsp_word.hit), 32'(want.hit));
                if (rsp_word.read_data !== want.read_data)
                    report_mismatch("read_data", rsp_word.read_data, want.read_data);
                if (rsp_word.insert_dropped !== want.insert_dropped)
                    report_mismatch("insert_dropped", 32'(rsp_word.insert_dropped),
                                    32'(want.insert_dropped));
                if (rsp_word.hit_total !== want.hit_total)
                    report_mismatch("hit_total", rsp_word.hit_total, want.hit_total);
                if (rsp_word.miss_total !== want.miss_total)
                    report_mismatch("miss_total", rsp_word.miss_total, want.miss_total);
                if (want.insert_dropped)
                    drops_seen++;
                if (want.hit)
                    hits_seen++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random words, drain and verdict.
    initial
    begin
        fac_req_t req;
        fac_rsp_t none;
        none         = '0;
        error_count  = 0;
        cycle_count  = 0;
        lookups_seen = 0;
        hits_seen    = 0;
        drops_seen   = 0;
        inserts_seen = 0;
        steady       = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_word     = '0;
        rsp_ready    = 1'b0;
        mdl_hits     = '0;
        mdl_misses   = '0;
        for (int i = 0; i < LINES; i++)
            mdl_valid[i] = 1'b0;

        // Extremes after reset, a duplicate insert and near-miss lookups.
        directed.push_back(make_row(FUNC_LOOKUP, 16'h0000, 32'h0000_0000, 1, 0, 0, 0, 0, 1));
        directed.push_back(make_row(FUNC_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 2));
        directed.push_back(make_row(FUNC_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 2));
        directed.push_back(make_row(FUNC_LOOKUP, 16'hFFFF, 32'h0000_0000, 1, 1, 32'h7FFF_FFFF,
                                    0, 1, 2));
        directed.push_back(make_row(FUNC_INSERT, 16'h0000, 32'h8000_0000, 1, 0, 0, 0, 1, 2));
        directed.push_back(make_row(FUNC_LOOKUP, 16'h0000, 32'h1234_5678, 1, 1, 32'h8000_0000,
                                    0, 2, 2));
        directed.push_back(make_row(FUNC_INSERT, 16'h1234, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_INSERT, 16'h1234, 32'h0000_0001, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_LOOKUP, 16'h1234, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_LOOKUP, 16'h1235, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_INSERT, 16'hAAAA, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_INSERT, 16'h5555, 32'h5555_5555, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_LOOKUP, 16'hAAAA, 32'h5555_5555, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_LOOKUP, 16'h5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(FUNC_LOOKUP, 16'h0001, 32'hDEAD_BEEF, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].req.func == FUNC_LOOKUP)
                lookups_seen++;
            else
                inserts_seen++;
            send_word(directed[i].req, directed[i].typed, directed[i].want);
        end
        hold_until_drained();

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            // A long stretch with neither side idling, and one more full drain.
            steady = (n >= 500 && n < 800);
            if (n == 1000)
                hold_until_drained();
            req = make_random_req();
            if (req.func == FUNC_LOOKUP)
                lookups_seen++;
            else
                inserts_seen++;
            send_word(req, 1'b0, none);
        end
        req_valid <= 1'b0;
        steady = 1'b0;

        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d lookups (%0d hits) and %0d inserts (%0d dropped on a full cache)",
                 lookups_seen, hits_seen, inserts_seen, drops_seen);
        $display("%0d mismatches over %0d cycles", error_count, cycle_count);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
